// File: rtl/assert_macros.svh
// Assertion helper macros for the task dependency tracker RTL.
// No dependencies; included by tdt_dpath, the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tdt_pkg.sv
// Package for the task dependency tracker: field widths, codes and transaction types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tdt_pkg;

  // Default number of tracked tasks
  localparam int unsigned MAX_TASKS_DEF = 16;

  // Field widths
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned TASK_W   = 4;
  localparam int unsigned TSTATE_W = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned CNT_W    = 5;

  // APB register file
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_TASK_COUNT = 1'b0;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ADD_EDGE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_STATE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESET_STATE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READY_QUERY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INDEP_QUERY = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXISTS  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_SELF    = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_CYCLE   = 3'd4;

  // Task states
  localparam logic [TSTATE_W-1:0] TASK_PENDING   = 2'd0;
  localparam logic [TSTATE_W-1:0] TASK_COMPLETED = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TASK_W-1:0]   task_a;
    logic [TASK_W-1:0]   task_b;
    logic [TSTATE_W-1:0] new_state;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   ready_mask;
    logic                independent;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming transaction, seed reach sets
    logic step;    // one closure pass over the matrix
    logic commit;  // write result and apply the state update
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_close;  // item needs a reachability closure
    logic grew;        // the current pass would add a task
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage

// File: rtl/tdt_ctrl.sv
// Sequencer of the task dependency tracker: accept, check, closure passes, commit.
// Depends on tdt_pkg for the command and status structs.
`timescale 1ns / 1ps

module tdt_ctrl #(
  parameter int unsigned MAX_TASKS = tdt_pkg::MAX_TASKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tdt_pkg::ctrl_sts_t   sts_i,
  output tdt_pkg::ctrl_cmd_t   cmd_o
);

  localparam int unsigned PASS_W = $clog2(MAX_TASKS);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(MAX_TASKS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_CLOSE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PASS_W-1:0] pass_q, pass_d;

  // Only one transaction in flight; the output register is separate
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    cmd_o       = '0;
    cmd_o.load  = in_valid_i && !in_stall_o;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        pass_d  = '0;
        state_d = sts_i.need_close ? S_CLOSE : S_DONE;
      end
      S_CLOSE: begin
        cmd_o.step = 1'b1;
        pass_d     = pass_q + 1'b1;
        if (!sts_i.grew || pass_q == PASS_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// File: rtl/tdt_dpath.sv
// Datapath of the task dependency tracker: dependency matrix, task states,
// reach sets for the closure, result logic and output register.
// Depends on tdt_pkg and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tdt_dpath #(
  parameter int unsigned MAX_TASKS = tdt_pkg::MAX_TASKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tdt_pkg::in_item_t                  in_item_i,
  input  logic [tdt_pkg::CNT_W-1:0]          task_count_i,
  input  tdt_pkg::ctrl_cmd_t                 cmd_i,
  output tdt_pkg::ctrl_sts_t                 sts_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tdt_pkg::out_item_t                 out_item_o
);

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);

  tdt_pkg::in_item_t  item_q;
  tdt_pkg::out_item_t out_item_q, result;
  logic               out_valid_q;

  logic [MAX_TASKS-1:0] rows_q [MAX_TASKS];
  logic [tdt_pkg::TSTATE_W-1:0] states_q [MAX_TASKS];
  logic [MAX_TASKS-1:0] reach_a_q, reach_b_q;
  logic [MAX_TASKS-1:0] init_a, init_b, nxt_a, nxt_b;
  logic [MAX_TASKS-1:0] completed, diag;
  logic [tdt_pkg::MASK_W-1:0] ready_mask;

  logic [IDX_W-1:0] a_idx, b_idx;
  logic a_ok, b_ok, same, edge_present;
  logic add_ok, set_ok, clr_states;

  // Ids of the held transaction
  assign a_idx = IDX_W'(item_q.task_a);
  assign b_idx = IDX_W'(item_q.task_b);
  assign a_ok  = (int'(item_q.task_a) < int'(task_count_i)) &&
                 (int'(item_q.task_a) < MAX_TASKS);
  assign b_ok  = (int'(item_q.task_b) < int'(task_count_i)) &&
                 (int'(item_q.task_b) < MAX_TASKS);
  assign same  = (item_q.task_a == item_q.task_b);
  assign edge_present = rows_q[b_idx][a_idx];

  // Seeds and one closure pass: a task joins when it depends on a reached task
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      init_a[i] = (int'(in_item_i.task_a) == i);
      init_b[i] = (int'(in_item_i.task_b) == i);
      nxt_a[i]  = reach_a_q[i] | (|(rows_q[i] & reach_a_q));
      nxt_b[i]  = reach_b_q[i] | (|(rows_q[i] & reach_b_q));
      completed[i] = (states_q[i] == tdt_pkg::TASK_COMPLETED);
      diag[i]      = rows_q[i][i];
    end
  end

  // Ready mask: pending, below the count, every dependency completed
  for (genvar g = 0; g < tdt_pkg::MASK_W; g++) begin : g_ready
    if (g < MAX_TASKS) begin : g_live
      assign ready_mask[g] = (int'(task_count_i) > g) &&
                             (states_q[g] == tdt_pkg::TASK_PENDING) &&
                             ((rows_q[g] & ~completed) == '0);
    end else begin : g_none
      assign ready_mask[g] = 1'b0;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.need_close = a_ok && b_ok &&
                       ((item_q.kind == tdt_pkg::KIND_INDEP_QUERY) ||
                        ((item_q.kind == tdt_pkg::KIND_ADD_EDGE) && !same && !edge_present));
    sts_o.grew       = (nxt_a != reach_a_q) || (nxt_b != reach_b_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Result of the held transaction
  always_comb begin
    result     = '0;
    add_ok     = 1'b0;
    set_ok     = 1'b0;
    clr_states = 1'b0;
    case (item_q.kind)
      tdt_pkg::KIND_ADD_EDGE: begin
        if (!a_ok || !b_ok) begin
          result.status = tdt_pkg::STATUS_INVALID;
        end else if (same) begin
          result.status = tdt_pkg::STATUS_SELF;
        end else if (edge_present) begin
          result.status = tdt_pkg::STATUS_EXISTS;
        end else if (reach_b_q[a_idx]) begin
          result.status = tdt_pkg::STATUS_CYCLE;
        end else begin
          add_ok = 1'b1;
        end
      end
      tdt_pkg::KIND_SET_STATE: begin
        if (a_ok) begin
          set_ok = 1'b1;
        end else begin
          result.status = tdt_pkg::STATUS_INVALID;
        end
      end
      tdt_pkg::KIND_RESET_STATE: begin
        clr_states = 1'b1;
      end
      tdt_pkg::KIND_READY_QUERY: begin
        result.ready_mask = ready_mask;
      end
      tdt_pkg::KIND_INDEP_QUERY: begin
        if (!a_ok || !b_ok) begin
          result.status = tdt_pkg::STATUS_INVALID;
        end else begin
          result.independent = !reach_a_q[b_idx] && !reach_b_q[a_idx];
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Held transaction and reach sets
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q    <= in_item_i;
      reach_a_q <= init_a;
      reach_b_q <= init_b;
    end else if (cmd_i.step) begin
      reach_a_q <= nxt_a;
      reach_b_q <= nxt_b;
    end
  end

  // Dependency matrix and task states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        rows_q[i]   <= '0;
        states_q[i] <= tdt_pkg::TASK_PENDING;
      end
    end else if (cmd_i.commit) begin
      if (add_ok) begin
        rows_q[b_idx][a_idx] <= 1'b1;
      end
      if (set_ok) begin
        states_q[a_idx] <= item_q.new_state;
      end
      if (clr_states) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          states_q[i] <= tdt_pkg::TASK_PENDING;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  `ASSERT_CLK(a_no_self_dep, clk_i, rst_ni, diag == '0, "task depends on itself")
  `ASSERT_NEXT(a_reach_grows, clk_i, rst_ni, cmd_i.step, ((reach_a_q & $past(reach_a_q)) == $past(reach_a_q)) && ((reach_b_q & $past(reach_b_q)) == $past(reach_b_q)), "reach set lost a task")
  `ASSERT_NEXT(a_edge_stored, clk_i, rst_ni, cmd_i.commit && add_ok, edge_present, "accepted edge not stored")
  `ASSERT_CLK(a_result_from_commit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.commit), "result without commit")

endmodule

// File: rtl/task_dependency_tracker_core.sv
// Task dependency tracker, top level: APB register, sequencer and datapath.
// One transaction at a time, each going through capture, check, up to MAX_TASKS
// closure passes and commit. The closure does one pass over the whole dependency
// matrix per cycle and stops as soon as a pass adds no task; only add-edge and the
// independence query run it. The next transaction is taken while a result still waits in
// the output register. No clearing pass after reset. Depends on tdt_pkg, tdt_ctrl, tdt_dpath.
`timescale 1ns / 1ps

module task_dependency_tracker_core #(
  parameter int unsigned MAX_TASKS = tdt_pkg::MAX_TASKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input transactions
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tdt_pkg::in_item_t                  in_item_i,
  // Result transactions
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tdt_pkg::out_item_t                 out_item_o,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tdt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tdt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tdt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  tdt_pkg::ctrl_cmd_t cmd;
  tdt_pkg::ctrl_sts_t sts;

  logic [tdt_pkg::CNT_W-1:0] task_count_q;
  logic                      reg_sel, cfg_we;

  // Task count register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tdt_pkg::REG_TASK_COUNT);
  assign cfg_we  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? tdt_pkg::APB_DATA_W'(task_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
    end else if (cfg_we) begin
      task_count_q <= pwdata[tdt_pkg::CNT_W-1:0];
    end
  end

  tdt_ctrl #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdt_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_item_i    (in_item_i),
    .task_count_i (task_count_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// File: test/tdt_checker.sv
// Checker for the task dependency tracker: watches the APB port and both channels, predicts
// each result from its own copy of the dependency matrix and task states, and compares.
// Depends on tdt_pkg.
`timescale 1ns / 1ps

module tdt_checker #(
  parameter int unsigned                     MAX_TASKS  = tdt_pkg::MAX_TASKS_DEF,
  parameter logic [tdt_pkg::APB_ADDR_W-1:0]  COUNT_ADDR = '0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  tdt_pkg::in_item_t                  in_item_i,
  // Result channel
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  tdt_pkg::out_item_t                 out_item_i,
  // APB port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tdt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tdt_pkg::APB_DATA_W-1:0]     pwdata,
  input  logic                               pready,
  // Status for the testbench top
  output int                                 fail_count_o,
  output int                                 pending_o
);

  // Shadow copy of the tracker state
  logic [MAX_TASKS-1:0]         prereq_rows [MAX_TASKS];  // bit j of row i: task i needs task j
  logic [tdt_pkg::TSTATE_W-1:0] task_state  [MAX_TASKS];
  logic [tdt_pkg::CNT_W-1:0]    task_limit;

  tdt_pkg::out_item_t results_due [$];
  tdt_pkg::out_item_t want;
  int                 mismatches = 0;
  int                 due_count  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_count;

  function automatic int unsigned live_tasks();
    return (task_limit > MAX_TASKS) ? MAX_TASKS : int'(task_limit);
  endfunction

  // Tasks reachable from src along prerequisite -> dependent edges, src included
  function automatic logic [MAX_TASKS-1:0] downstream_of(input int unsigned src);
    logic [MAX_TASKS-1:0] reach;
    reach      = '0;
    reach[src] = 1'b1;
    for (int p = 0; p < MAX_TASKS; p++) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (!reach[i] && |(prereq_rows[i] & reach)) reach[i] = 1'b1;
      end
    end
    return reach;
  endfunction

  // Apply one command to the shadow state and return the result it must produce
  function automatic tdt_pkg::out_item_t run_command(input tdt_pkg::in_item_t cmd);
    tdt_pkg::out_item_t   res;
    int unsigned          n;
    logic                 a_ok;
    logic                 b_ok;
    logic                 ok;
    logic [MAX_TASKS-1:0] fwd;
    logic [MAX_TASKS-1:0] bwd;
    res  = '0;
    n    = live_tasks();
    a_ok = cmd.task_a < n;
    b_ok = cmd.task_b < n;
    case (cmd.kind)
      tdt_pkg::KIND_ADD_EDGE: begin
        if (!a_ok || !b_ok) begin
          res.status = tdt_pkg::STATUS_INVALID;
        end else if (cmd.task_a == cmd.task_b) begin
          res.status = tdt_pkg::STATUS_SELF;
        end else if (prereq_rows[cmd.task_b][cmd.task_a]) begin
          res.status = tdt_pkg::STATUS_EXISTS;
        end else begin
          // a new edge a -> b closes a loop when b already leads to a
          fwd = downstream_of(cmd.task_b);
          if (fwd[cmd.task_a]) res.status = tdt_pkg::STATUS_CYCLE;
          else prereq_rows[cmd.task_b][cmd.task_a] = 1'b1;
        end
      end
      tdt_pkg::KIND_SET_STATE: begin
        if (!a_ok) res.status = tdt_pkg::STATUS_INVALID;
        else task_state[cmd.task_a] = cmd.new_state;
      end
      tdt_pkg::KIND_RESET_STATE: begin
        for (int i = 0; i < MAX_TASKS; i++) task_state[i] = tdt_pkg::TASK_PENDING;
      end
      tdt_pkg::KIND_READY_QUERY: begin
        // dropped tasks still count as prerequisites
        for (int i = 0; i < n && i < tdt_pkg::MASK_W; i++) begin
          ok = (task_state[i] == tdt_pkg::TASK_PENDING);
          for (int j = 0; j < MAX_TASKS; j++) begin
            if (prereq_rows[i][j] && task_state[j] != tdt_pkg::TASK_COMPLETED) ok = 1'b0;
          end
          res.ready_mask[i] = ok;
        end
      end
      tdt_pkg::KIND_INDEP_QUERY: begin
        if (!a_ok || !b_ok) begin
          res.status = tdt_pkg::STATUS_INVALID;
        end else begin
          fwd = downstream_of(cmd.task_a);
          bwd = downstream_of(cmd.task_b);
          res.independent = !fwd[cmd.task_b] && !bwd[cmd.task_a];
        end
      end
      default: ;  // unused kinds leave everything as is
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_limit = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        prereq_rows[i] = '0;
        task_state[i]  = tdt_pkg::TASK_PENDING;
      end
      results_due.delete();
      due_count = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
        task_limit = pwdata[tdt_pkg::CNT_W-1:0];

      // result transactions
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: status %0d ready_mask %h independent %0b",
                   $time, out_item_i.status, out_item_i.ready_mask, out_item_i.independent);
        end else begin
          want = results_due.pop_front();
          if (out_item_i.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_item_i.status);
          end
          if (out_item_i.ready_mask !== want.ready_mask) begin
            mismatches++;
            $display("%0t: ready_mask expected %h, got %h",
                     $time, want.ready_mask, out_item_i.ready_mask);
          end
          if (out_item_i.independent !== want.independent) begin
            mismatches++;
            $display("%0t: independent expected %0b, got %0b",
                     $time, want.independent, out_item_i.independent);
          end
        end
      end

      // input transactions: queue the predicted result at the tail
      if (in_valid_i && !in_stall_i) results_due = {results_due, run_command(in_item_i)};
      due_count = results_due.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the task dependency tracker: clock, reset, APB writes, directed and
// random command streams with random gaps and result stalls, and the final verdict.
// Depends on tdt_pkg, task_dependency_tracker_core and tdt_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = tdt_pkg::MAX_TASKS_DEF + 4;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned NUM_PHASES   = 8;

  localparam logic [tdt_pkg::APB_ADDR_W-1:0] TASK_COUNT_ADDR = {tdt_pkg::REG_TASK_COUNT, 2'b00};

  // Kinds the block ignores, and the task states the package leaves unnamed
  localparam logic [tdt_pkg::KIND_W-1:0]   KIND_RSVD_LO = 3'd5;
  localparam logic [tdt_pkg::KIND_W-1:0]   KIND_RSVD_HI = 3'd7;
  localparam logic [tdt_pkg::TSTATE_W-1:0] TASK_RUNNING = 2'd1;
  localparam logic [tdt_pkg::TSTATE_W-1:0] TASK_FAILED  = 2'd3;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  tdt_pkg::in_item_t                  in_item_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  tdt_pkg::out_item_t                 out_item_o;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [tdt_pkg::APB_ADDR_W-1:0]     paddr;
  logic [tdt_pkg::APB_DATA_W-1:0]     pwdata;
  logic [tdt_pkg::APB_DATA_W-1:0]     prdata;
  logic                               pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit steady      = 1'b0;  // no gaps and no stalls while set

  int unsigned phase_count [NUM_PHASES] = '{16, 31, 8, 0, 17, 2, 1, 12};

  task_dependency_tracker_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tdt_checker #(
    .COUNT_ADDR (TASK_COUNT_ADDR)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: a fresh stall length for every result
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // APB write: setup cycle, then access cycle
  task automatic cfg_write(input logic [tdt_pkg::APB_ADDR_W-1:0] addr,
                           input logic [tdt_pkg::APB_DATA_W-1:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Send one transaction after a random gap; returns at the falling edge after acceptance
  task automatic issue(input tdt_pkg::in_item_t cmd);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  = cmd;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Wait until every result is back and the block has gone quiet
  task automatic quiesce();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic tdt_pkg::in_item_t make_cmd(input logic [tdt_pkg::KIND_W-1:0] kind,
                                                 input logic [tdt_pkg::TASK_W-1:0] a,
                                                 input logic [tdt_pkg::TASK_W-1:0] b,
                                                 input logic [tdt_pkg::TSTATE_W-1:0] st);
    tdt_pkg::in_item_t cmd;
    cmd.kind      = kind;
    cmd.task_a    = a;
    cmd.task_b    = b;
    cmd.new_state = st;
    return cmd;
  endfunction

  // Mostly well-formed commands over the live ids; a share of raw noise
  function automatic tdt_pkg::in_item_t random_cmd(input int unsigned n);
    tdt_pkg::in_item_t cmd;
    int unsigned       pick;
    cmd.kind      = tdt_pkg::KIND_W'($urandom_range(0, 7));
    cmd.task_a    = tdt_pkg::TASK_W'($urandom_range(0, 15));
    cmd.task_b    = tdt_pkg::TASK_W'($urandom_range(0, 15));
    cmd.new_state = tdt_pkg::TSTATE_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      cmd.kind = tdt_pkg::KIND_ADD_EDGE;
      // forward edges build deep chains; the rest may close loops
      if (n >= 2 && pick < 28) begin
        cmd.task_a = tdt_pkg::TASK_W'($urandom_range(0, n - 2));
        cmd.task_b = tdt_pkg::TASK_W'($urandom_range(cmd.task_a + 1, n - 1));
      end else if (n >= 1 && pick < 33) begin
        cmd.task_a = tdt_pkg::TASK_W'($urandom_range(0, n - 1));
        cmd.task_b = tdt_pkg::TASK_W'($urandom_range(0, n - 1));
      end
    end else if (pick < 60) begin
      cmd.kind = tdt_pkg::KIND_SET_STATE;
      if (n >= 1 && $urandom_range(0, 9) != 0) begin
        cmd.task_a = tdt_pkg::TASK_W'($urandom_range(0, n - 1));
      end
      if ($urandom_range(0, 9) < 6) cmd.new_state = tdt_pkg::TASK_COMPLETED;
    end else if (pick < 64) begin
      cmd.kind = tdt_pkg::KIND_RESET_STATE;
    end else if (pick < 78) begin
      cmd.kind = tdt_pkg::KIND_READY_QUERY;
    end else if (pick < 93) begin
      cmd.kind = tdt_pkg::KIND_INDEP_QUERY;
      if (n >= 1 && $urandom_range(0, 9) != 0) begin
        cmd.task_a = tdt_pkg::TASK_W'($urandom_range(0, n - 1));
        cmd.task_b = tdt_pkg::TASK_W'($urandom_range(0, n - 1));
      end
    end
    return cmd;
  endfunction

  // Stimulus and verdict
  initial begin
    int unsigned live;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: full task set
    cfg_write(TASK_COUNT_ADDR, 16);
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 0, 1, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 0, 1, tdt_pkg::TASK_PENDING));    // duplicate edge
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 1, 2, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 2, 0, tdt_pkg::TASK_PENDING));    // closes a loop
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 5, 5, tdt_pkg::TASK_PENDING));    // self edge
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 15, 14, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 15, 2, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_READY_QUERY, 0, 0, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_SET_STATE, 0, 0, tdt_pkg::TASK_COMPLETED));
    issue(make_cmd(tdt_pkg::KIND_SET_STATE, 15, 0, TASK_FAILED));
    issue(make_cmd(tdt_pkg::KIND_SET_STATE, 3, 0, TASK_RUNNING));
    issue(make_cmd(tdt_pkg::KIND_READY_QUERY, 0, 0, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_INDEP_QUERY, 0, 2, tdt_pkg::TASK_PENDING)); // path through 1
    issue(make_cmd(tdt_pkg::KIND_INDEP_QUERY, 3, 4, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_INDEP_QUERY, 7, 7, tdt_pkg::TASK_PENDING)); // same task twice
    issue(make_cmd(tdt_pkg::KIND_INDEP_QUERY, 14, 15, tdt_pkg::TASK_PENDING));
    issue(make_cmd(KIND_RSVD_HI, 15, 15, TASK_FAILED));      // ignored kind, all ones
    issue(make_cmd(KIND_RSVD_LO, 0, 0, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_RESET_STATE, 0, 0, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_READY_QUERY, 0, 0, tdt_pkg::TASK_PENDING));
    quiesce();

    // Directed: shrunk task set, invalid ids and dropped prerequisites
    cfg_write(TASK_COUNT_ADDR, 3);
    issue(make_cmd(tdt_pkg::KIND_ADD_EDGE, 0, 5, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_SET_STATE, 3, 0, tdt_pkg::TASK_COMPLETED));
    issue(make_cmd(tdt_pkg::KIND_INDEP_QUERY, 0, 3, tdt_pkg::TASK_PENDING));
    issue(make_cmd(tdt_pkg::KIND_SET_STATE, 0, 0, tdt_pkg::TASK_COMPLETED));
    issue(make_cmd(tdt_pkg::KIND_SET_STATE, 1, 0, tdt_pkg::TASK_COMPLETED));
    issue(make_cmd(tdt_pkg::KIND_READY_QUERY, 0, 0, tdt_pkg::TASK_PENDING)); // 2 waits on 15
    quiesce();

    // Random phases over several task counts
    phase_count[NUM_PHASES - 1] = $urandom_range(3, 15);
    for (int p = 0; p < NUM_PHASES; p++) begin
      steady = ($urandom_range(0, 3) == 0);
      cfg_write(TASK_COUNT_ADDR, phase_count[p]);
      live = (phase_count[p] > tdt_pkg::MAX_TASKS_DEF) ? tdt_pkg::MAX_TASKS_DEF : phase_count[p];
      repeat (PHASE_ITEMS) issue(random_cmd(live));
      quiesce();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
